>>> rtl/lwps_pkg.sv
// Package for the longest-waiting packet server.
// Holds queue sizing, the entry and scan-token types, the cell control bundle
// and the saturating wait increment. No dependencies.
`default_nettype none

package lwps_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] WAIT_MAX   = 16'hFFFF;
  localparam logic [15:0] WAIT_START = 16'd1;

  typedef struct packed {
    logic [7:0]  rem;
    logic [15:0] wait_cnt;
    logic [31:0] arr;
  } entry_t;

  // Best-so-far candidate handed from cell to cell during the search.
  typedef struct packed {
    logic             valid;
    logic [15:0]      wait_cnt;
    logic [IDX_W-1:0] idx;
    logic [7:0]       rem;
    logic [31:0]      arr;
  } token_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic             insert;
    logic             commit;
    logic             serve;
    logic             remove;
    logic [IDX_W-1:0] best_idx;
    logic [CNT_W-1:0] count;
  } cell_ctl_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] w);
    sat_inc = (w == WAIT_MAX) ? w : w + 16'd1;
  endfunction

endpackage

`default_nettype wire

>>> rtl/lwps_cell.sv
// One queue slot of the longest-waiting packet server.
// Holds one entry, shifts with its neighbours and passes the search token on.
// Depends on lwps_pkg.
`default_nettype none

module lwps_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [lwps_pkg::IDX_W-1:0] my_idx,
  input  wire lwps_pkg::cell_ctl_t        ctl,
  input  wire lwps_pkg::entry_t           front,
  input  wire lwps_pkg::entry_t           back,
  input  wire lwps_pkg::token_t           tok_in,
  output lwps_pkg::entry_t                ent,
  output lwps_pkg::token_t                tok_out
);

  logic occupied;
  logic is_best;
  logic take_back;

  assign occupied  = lwps_pkg::CNT_W'(my_idx) < ctl.count;
  assign is_best   = (my_idx == ctl.best_idx);
  assign take_back = ctl.serve && ctl.remove && (my_idx >= ctl.best_idx);

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      ent <= front;
    end else if (ctl.commit) begin
      if (take_back) begin
        // close the gap left by the finished packet
        ent.rem      <= back.rem;
        ent.arr      <= back.arr;
        ent.wait_cnt <= lwps_pkg::sat_inc(back.wait_cnt);
      end else if (ctl.serve && is_best) begin
        ent.rem      <= ent.rem - 8'd1;
        ent.wait_cnt <= lwps_pkg::WAIT_START;
      end else begin
        ent.wait_cnt <= lwps_pkg::sat_inc(ent.wait_cnt);
      end
    end
  end

  // strictly greater keeps ties with the entry nearest the front
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    if (occupied && (ent.wait_cnt > tok_in.wait_cnt)) begin
      tok_out.wait_cnt <= ent.wait_cnt;
      tok_out.idx      <= my_idx;
      tok_out.rem      <= ent.rem;
      tok_out.arr      <= ent.arr;
    end else begin
      tok_out.wait_cnt <= tok_in.wait_cnt;
      tok_out.idx      <= tok_in.idx;
      tok_out.rem      <= tok_in.rem;
      tok_out.arr      <= tok_in.arr;
    end
  end

endmodule

`default_nettype wire

>>> rtl/longest_waiting_packet_server.sv
// Top level of the longest-waiting packet server: tick controller and row of cells.
// Depends on lwps_pkg and lwps_cell.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  tick in  | start, busy          | arrival, packet_size
//  result   | out_valid (1 cycle)  | done_valid, done_delay, dropped, queue_count
//  config   | cfg_we               | cfg_wdata (serve_alternate_ticks)
//
// A serving tick's length is set by the token walking the cell row one slot a cycle;
// busy holds from accept until the tick commits; no new tick is taken meanwhile.
// A tick with no service (empty queue or off phase) skips the scan.
// The result beat is registered and shows in the cycle after the tick commits;
// the receiver cannot stall it, and a new tick may be taken while it shows.
// Synchronous reset clears count, tick counter, drop flag and out_valid, and
// sets phase and alt; slots need no clearing since only those below count are read.
`default_nettype none

module longest_waiting_packet_server (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        arrival,
  input  wire logic [7:0]  packet_size,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  output logic             out_valid,
  output logic             done_valid,
  output logic [31:0]      done_delay,
  output logic             dropped,
  output logic [4:0]       queue_count
);

  localparam int D = lwps_pkg::QUEUE_DEPTH;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                     state;
  logic [lwps_pkg::CNT_W-1:0] count;
  logic [lwps_pkg::CNT_W-1:0] count_next;
  logic                       phase;
  logic [31:0]                tick;
  logic                       alt;
  logic                       drop_flag;

  logic                       accept;
  logic                       full;
  logic                       do_insert;
  logic                       serve_now;
  logic                       commit;
  logic                       serving;
  logic                       remove;

  lwps_pkg::entry_t           ent [D];
  lwps_pkg::token_t           tok [D];
  lwps_pkg::entry_t           new_ent;
  lwps_pkg::token_t           inject;
  lwps_pkg::cell_ctl_t        ctl;
  lwps_pkg::token_t           tail;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign full      = (count == lwps_pkg::CNT_W'(D));
  assign do_insert = accept && arrival && !full;
  assign serve_now = (phase || !alt) && (count != '0);
  assign tail      = tok[D-1];
  assign commit    = ((state == ST_SCAN) && tail.valid) || (state == ST_FINISH);
  assign serving   = (state == ST_SCAN);
  assign remove    = serving && (tail.rem <= 8'd1);
  assign count_next = count - lwps_pkg::CNT_W'(remove);

  assign new_ent.rem      = packet_size;
  assign new_ent.wait_cnt = lwps_pkg::WAIT_START;
  assign new_ent.arr      = tick;

  // the search starts below any live wait, so the front slot always wins first
  assign inject.valid    = (state == ST_LAUNCH) && serve_now;
  assign inject.wait_cnt = '0;
  assign inject.idx      = '0;
  assign inject.rem      = '0;
  assign inject.arr      = '0;

  assign ctl.insert   = do_insert;
  assign ctl.commit   = commit;
  assign ctl.serve    = serving;
  assign ctl.remove   = remove;
  assign ctl.best_idx = tail.idx;
  assign ctl.count    = count;

  for (genvar j = 0; j < D; j++) begin : g_cell
    lwps_pkg::entry_t front_j;
    lwps_pkg::entry_t back_j;
    lwps_pkg::token_t tin_j;

    if (j == 0) begin : g_first
      assign front_j = new_ent;
      assign tin_j   = inject;
    end else begin : g_mid
      assign front_j = ent[j-1];
      assign tin_j   = tok[j-1];
    end

    if (j == D - 1) begin : g_last
      assign back_j = '0;
    end else begin : g_inner
      assign back_j = ent[j+1];
    end

    lwps_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .my_idx  (lwps_pkg::IDX_W'(j)),
      .ctl     (ctl),
      .front   (front_j),
      .back    (back_j),
      .tok_in  (tin_j),
      .ent     (ent[j]),
      .tok_out (tok[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      phase     <= 1'b1;
      tick      <= '0;
      alt       <= 1'b1;
      drop_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) begin
        alt <= cfg_wdata;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            drop_flag <= arrival && full;
            if (do_insert) begin
              count <= count + lwps_pkg::CNT_W'(1);
            end
            state <= ST_LAUNCH;
          end
        end
        ST_LAUNCH: begin
          state <= serve_now ? ST_SCAN : ST_FINISH;
        end
        ST_SCAN, ST_FINISH: begin
          if (commit) begin
            count     <= count_next;
            phase     <= !phase;
            tick      <= tick + 32'd1;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result payload, held until the next tick completes
  always_ff @(posedge clk) begin
    if (commit) begin
      done_valid  <= remove;
      done_delay  <= remove ? (tick - tail.arr) : 32'd0;
      dropped     <= drop_flag;
      queue_count <= 5'(count_next);
    end
  end

endmodule

`default_nettype wire
